// ===== design/acea_pkg.sv =====
// ----------------------------------------------------------------------------
// acea_pkg: shared constants for the atom contact energy accumulator
// Widths of coordinates, distances, the square-root and divider datapaths,
// and the saturation limits of the running sum.
// ----------------------------------------------------------------------------
package acea_pkg;

   // Coordinate width of one atom position, signed, 8 fraction bits.
   localparam int COORD_WIDTH = 20;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;

   // A coordinate difference of 2^FAR_BITS or more puts the atoms out of range.
   localparam int FAR_BITS  = 17;
   localparam int MAG_WIDTH = (DIFF_WIDTH > FAR_BITS + 1) ? DIFF_WIDTH : FAR_BITS + 1;
   localparam logic [MAG_WIDTH-1:0] FAR_LIMIT = MAG_WIDTH'(1) << FAR_BITS;

   // Sum of three squares of FAR_BITS-bit magnitudes.
   localparam int SQ_WIDTH      = 2 * FAR_BITS + 2;
   localparam int SQ_HI_WIDTH   = SQ_WIDTH - FAR_BITS;
   localparam int SQ_SUM_WIDTH  = SQ_HI_WIDTH + 1;
   localparam int SQ_CNT_WIDTH  = $clog2(FAR_BITS);

   // Integer square root.
   localparam int ROOT_WIDTH     = SQ_WIDTH / 2;
   localparam int REM_WIDTH      = ROOT_WIDTH + 1;
   localparam int ROOT_CNT_WIDTH = $clog2(ROOT_WIDTH);

   // Probe width, distances, weights and the scaling divider.
   localparam int PW_WIDTH       = 16;
   localparam int DIST_WIDTH     = 16;
   localparam int WEIGHT_WIDTH   = 16;
   localparam int PROD_WIDTH     = 2 * PW_WIDTH;
   localparam int DIV_CNT_WIDTH  = $clog2(PW_WIDTH);
   localparam logic [PW_WIDTH-1:0] PW_RESET = PW_WIDTH'(256);

   // Running sum.
   localparam int SUM_WIDTH = 32;
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

endpackage

// ===== design/acea_isqrt.sv =====
// ----------------------------------------------------------------------------
// acea_isqrt: bit-serial integer square root
// Restoring digit-by-digit root, one result bit per cycle, two radicand
// bits consumed per cycle from a shift register.
// ----------------------------------------------------------------------------
module acea_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [acea_pkg::SQ_WIDTH-1:0]      radicand,
   output logic                               done,
   output logic [acea_pkg::ROOT_WIDTH-1:0]    root
);

   logic [acea_pkg::SQ_WIDTH-1:0]        rad_ff;
   logic [acea_pkg::REM_WIDTH-1:0]       rem_ff;
   logic [acea_pkg::ROOT_WIDTH-1:0]      root_ff;
   logic [acea_pkg::ROOT_CNT_WIDTH-1:0]  cnt_ff;
   logic                                 busy_ff;
   logic                                 done_ff;

   logic [acea_pkg::REM_WIDTH+1:0]       rem_shift;
   logic [acea_pkg::REM_WIDTH+1:0]       trial;
   logic                                 fits;
   logic [acea_pkg::REM_WIDTH-1:0]       rem_in;
   logic [acea_pkg::ROOT_WIDTH-1:0]      root_in;

   always_comb begin
      rem_shift = {rem_ff, rad_ff[acea_pkg::SQ_WIDTH-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      fits      = (rem_shift >= trial);
      // The remainder never exceeds twice the partial root, so it fits back.
      if (fits) begin
         rem_in = acea_pkg::REM_WIDTH'(rem_shift - trial);
      end else begin
         rem_in = rem_shift[acea_pkg::REM_WIDTH-1:0];
      end
      root_in = {root_ff[acea_pkg::ROOT_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= acea_pkg::ROOT_CNT_WIDTH'(acea_pkg::ROOT_WIDTH - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rad_ff  <= rad_ff << 2;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== design/acea_divu.sv =====
// ----------------------------------------------------------------------------
// acea_divu: bit-serial unsigned divider
// Restoring division of a double-width dividend by the probe width, one
// quotient bit per cycle. The upper dividend half must be below the divisor.
// ----------------------------------------------------------------------------
module acea_divu (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [acea_pkg::PROD_WIDTH-1:0]    dividend,
   input  logic [acea_pkg::PW_WIDTH-1:0]      divisor,
   output logic                               done,
   output logic [acea_pkg::PW_WIDTH-1:0]      quotient
);

   logic [acea_pkg::PW_WIDTH-1:0]       rem_ff;
   logic [acea_pkg::PW_WIDTH-1:0]       quo_ff;
   logic [acea_pkg::PW_WIDTH-1:0]       div_ff;
   logic [acea_pkg::DIV_CNT_WIDTH-1:0]  cnt_ff;
   logic                                busy_ff;
   logic                                done_ff;

   logic [acea_pkg::PW_WIDTH:0]         partial;
   logic                                fits;
   logic [acea_pkg::PW_WIDTH-1:0]       rem_in;

   always_comb begin
      partial = {rem_ff, quo_ff[acea_pkg::PW_WIDTH-1]};
      fits    = (partial >= {1'b0, div_ff});
      if (fits) begin
         rem_in = acea_pkg::PW_WIDTH'(partial - {1'b0, div_ff});
      end else begin
         rem_in = partial[acea_pkg::PW_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= dividend[acea_pkg::PROD_WIDTH-1:acea_pkg::PW_WIDTH];
            quo_ff  <= dividend[acea_pkg::PW_WIDTH-1:0];
            div_ff  <= divisor;
            cnt_ff  <= acea_pkg::DIV_CNT_WIDTH'(acea_pkg::PW_WIDTH - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[acea_pkg::PW_WIDTH-2:0], fits};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/atom_contact_energy_accumulator.sv =====
// ----------------------------------------------------------------------------
// atom_contact_energy_accumulator: contact energy term and running score
// Per contact: distance between two atoms, linear fall-off of the weight
// across the probe zone, saturating running sum, negated score output.
// ----------------------------------------------------------------------------
//
//   Channel | Prefix | Direction | Carries
//   --------+--------+-----------+------------------------------------------
//   Request | req_   | in        | two atom positions, full distance, weight
//   Result  | rsp_   | out       | term, negated running score, list done
//   CSR     | csr_   | in        | probe width (always ready)
//
// One request is in work at a time. An out-of-range request goes from
// acceptance straight to the finish step. Others run the serial sum of
// squares and the bit-serial root, then the decide step, and the bit-serial
// divider when the distance falls in the probe zone, then the finish step;
// each serial unit gets a start strobe and answers with a done strobe. A new
// request is taken while the result register still waits on rsp_ready; only
// the final write stalls on it.
// Reset (synchronous) clears the running sum and sets the probe width to 1.0.
//
module atom_contact_energy_accumulator (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_first_x,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_first_y,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_first_z,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_second_x,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_second_y,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_second_z,
   input  logic [acea_pkg::DIST_WIDTH-1:0]           req_full_distance,
   input  logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  req_weight,
   input  logic                                      req_final_contact,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  rsp_term,
   output logic signed [acea_pkg::SUM_WIDTH-1:0]     rsp_score,
   output logic                                      rsp_done_res,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [acea_pkg::PW_WIDTH-1:0]             csr_probe_width
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_ROOT,
      S_SCALE,
      S_DIVIDE,
      S_FINISH
   } state_type;

   function automatic logic [acea_pkg::DIFF_WIDTH-1:0] abs_diff(
      input logic [acea_pkg::COORD_WIDTH-1:0] a,
      input logic [acea_pkg::COORD_WIDTH-1:0] b
   );
      logic [acea_pkg::DIFF_WIDTH-1:0] d;
      d = {a[acea_pkg::COORD_WIDTH-1], a} - {b[acea_pkg::COORD_WIDTH-1], b};
      return d[acea_pkg::DIFF_WIDTH-1] ? (~d + 1'b1) : d;
   endfunction

   state_type                                 state_ff;
   logic [acea_pkg::FAR_BITS-1:0]             dx_ff, dy_ff, dz_ff;
   logic [acea_pkg::FAR_BITS-1:0]             mx_ff, my_ff, mz_ff;
   logic [acea_pkg::SQ_HI_WIDTH-1:0]          sq_hi_ff;
   logic [acea_pkg::FAR_BITS-1:0]             sq_lo_ff;
   logic [acea_pkg::SQ_CNT_WIDTH-1:0]         cnt_ff;
   logic [acea_pkg::DIST_WIDTH-1:0]           dmin_ff;
   logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  weight_ff;
   logic                                      last_ff;
   logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  term_ff;
   logic [acea_pkg::PROD_WIDTH-1:0]           mag_ff;
   logic                                      root_start_ff;
   logic                                      div_start_ff;
   logic [acea_pkg::PW_WIDTH-1:0]             pw_ff;
   logic signed [acea_pkg::SUM_WIDTH-1:0]     sum_ff;
   logic                                      rsp_valid_ff;
   logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  rsp_term_ff;
   logic signed [acea_pkg::SUM_WIDTH-1:0]     rsp_score_ff;
   logic                                      rsp_done_ff;

   logic [acea_pkg::DIFF_WIDTH-1:0]           ax, ay, az;
   logic                                      far;
   logic [acea_pkg::SQ_SUM_WIDTH-1:0]         sq_sum;
   logic                                      root_done;
   logic [acea_pkg::ROOT_WIDTH-1:0]           root;
   logic                                      div_done;
   logic [acea_pkg::PW_WIDTH-1:0]             quotient;
   logic [acea_pkg::ROOT_WIDTH-1:0]           dmin_ext;
   logic [acea_pkg::ROOT_WIDTH-1:0]           dmax_ext;
   logic [acea_pkg::PW_WIDTH-1:0]             span;
   logic [acea_pkg::WEIGHT_WIDTH-1:0]         abs_weight;
   logic [acea_pkg::PROD_WIDTH-1:0]           mag_in;
   logic [acea_pkg::WEIGHT_WIDTH-1:0]         signed_quo;
   logic [acea_pkg::SUM_WIDTH:0]              wide_sum;
   logic signed [acea_pkg::SUM_WIDTH-1:0]     sum_in;
   logic signed [acea_pkg::SUM_WIDTH-1:0]     score_in;
   logic                                      out_free;

   // Request decode: coordinate differences and the out-of-range check.
   always_comb begin
      ax  = abs_diff(req_first_x, req_second_x);
      ay  = abs_diff(req_first_y, req_second_y);
      az  = abs_diff(req_first_z, req_second_z);
      far = (acea_pkg::MAG_WIDTH'(ax) >= acea_pkg::FAR_LIMIT)
         || (acea_pkg::MAG_WIDTH'(ay) >= acea_pkg::FAR_LIMIT)
         || (acea_pkg::MAG_WIDTH'(az) >= acea_pkg::FAR_LIMIT);
   end

   // Shift-and-add of all three squares at once; low product bits drop into
   // sq_lo_ff one per cycle while the upper part stays narrow.
   always_comb begin
      sq_sum = {1'b0, sq_hi_ff}
             + (mx_ff[0] ? acea_pkg::SQ_SUM_WIDTH'(dx_ff) : '0)
             + (my_ff[0] ? acea_pkg::SQ_SUM_WIDTH'(dy_ff) : '0)
             + (mz_ff[0] ? acea_pkg::SQ_SUM_WIDTH'(dz_ff) : '0);
   end

   // Scale decision once the root is known.
   always_comb begin
      dmin_ext   = acea_pkg::ROOT_WIDTH'(dmin_ff);
      dmax_ext   = acea_pkg::ROOT_WIDTH'(dmin_ff) + acea_pkg::ROOT_WIDTH'(pw_ff);
      span       = acea_pkg::PW_WIDTH'(dmax_ext - root);
      abs_weight = weight_ff[acea_pkg::WEIGHT_WIDTH-1] ? (~weight_ff + 1'b1) : weight_ff;
      mag_in     = acea_pkg::PROD_WIDTH'(abs_weight) * acea_pkg::PROD_WIDTH'(span);
      signed_quo = weight_ff[acea_pkg::WEIGHT_WIDTH-1] ? (~quotient + 1'b1) : quotient;
   end

   // Saturating accumulate and negated score.
   always_comb begin
      wide_sum = {sum_ff[acea_pkg::SUM_WIDTH-1], sum_ff}
               + (acea_pkg::SUM_WIDTH+1)'(term_ff);
      if (wide_sum[acea_pkg::SUM_WIDTH] != wide_sum[acea_pkg::SUM_WIDTH-1]) begin
         sum_in = wide_sum[acea_pkg::SUM_WIDTH] ? acea_pkg::SUM_MIN : acea_pkg::SUM_MAX;
      end else begin
         sum_in = wide_sum[acea_pkg::SUM_WIDTH-1:0];
      end
      if (sum_in == acea_pkg::SUM_MIN) begin
         score_in = acea_pkg::SUM_MAX;
      end else begin
         score_in = -sum_in;
      end
      out_free = !rsp_valid_ff || rsp_ready;
   end

   acea_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start_ff),
      .radicand ({sq_hi_ff, sq_lo_ff}),
      .done     (root_done),
      .root     (root)
   );

   acea_divu u_divu (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (mag_ff),
      .divisor  (pw_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         pw_ff         <= acea_pkg::PW_RESET;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         root_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         if (csr_valid) begin
            pw_ff <= csr_probe_width;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  dx_ff     <= ax[acea_pkg::FAR_BITS-1:0];
                  dy_ff     <= ay[acea_pkg::FAR_BITS-1:0];
                  dz_ff     <= az[acea_pkg::FAR_BITS-1:0];
                  mx_ff     <= ax[acea_pkg::FAR_BITS-1:0];
                  my_ff     <= ay[acea_pkg::FAR_BITS-1:0];
                  mz_ff     <= az[acea_pkg::FAR_BITS-1:0];
                  sq_hi_ff  <= '0;
                  sq_lo_ff  <= '0;
                  cnt_ff    <= acea_pkg::SQ_CNT_WIDTH'(acea_pkg::FAR_BITS - 1);
                  dmin_ff   <= req_full_distance;
                  weight_ff <= req_weight;
                  last_ff   <= req_final_contact;
                  term_ff   <= '0;
                  state_ff  <= far ? S_FINISH : S_SQUARE;
               end
            end
            S_SQUARE: begin
               sq_hi_ff <= sq_sum[acea_pkg::SQ_SUM_WIDTH-1:1];
               sq_lo_ff <= {sq_sum[0], sq_lo_ff[acea_pkg::FAR_BITS-1:1]};
               mx_ff    <= mx_ff >> 1;
               my_ff    <= my_ff >> 1;
               mz_ff    <= mz_ff >> 1;
               cnt_ff   <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  root_start_ff <= 1'b1;
                  state_ff      <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (root_done) begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               // With a zero probe width the middle zone is empty.
               if (root < dmin_ext) begin
                  term_ff  <= weight_ff;
                  state_ff <= S_FINISH;
               end else if (root < dmax_ext) begin
                  mag_ff       <= mag_in;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIVIDE;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_DIVIDE: begin
               if (div_done) begin
                  term_ff  <= signed_quo;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  sum_ff       <= last_ff ? '0 : sum_in;
                  rsp_term_ff  <= term_ff;
                  rsp_score_ff <= score_in;
                  rsp_done_ff  <= last_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_term     = rsp_term_ff;
   assign rsp_score    = rsp_score_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

// ===== design/acea_checker.sv =====
// ----------------------------------------------------------------------------
// acea_checker: port-level checks for the contact energy accumulator
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module acea_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_ready,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_first_x,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_first_y,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_first_z,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_second_x,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_second_y,
   input  logic signed [acea_pkg::COORD_WIDTH-1:0]   req_second_z,
   input  logic [acea_pkg::DIST_WIDTH-1:0]           req_full_distance,
   input  logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  req_weight,
   input  logic                                      req_final_contact,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   input  logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  rsp_term,
   input  logic signed [acea_pkg::SUM_WIDTH-1:0]     rsp_score,
   input  logic                                      rsp_done_res,
   input  logic                                      csr_valid,
   input  logic                                      csr_ready,
   input  logic [acea_pkg::PW_WIDTH-1:0]             csr_probe_width
);

   // A result that is not taken holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_term)
         && $stable(rsp_score) && $stable(rsp_done_res))
      else $error("result changed while stalled");

   // Only one request is in work: the block is busy right after taking one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // Coming out of reset the block is idle with no result pending.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // The negated saturated total can never reach the most negative value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_score != acea_pkg::SUM_MIN)
      else $error("score holds the most negative value");

endmodule

bind atom_contact_energy_accumulator acea_checker u_acea_checker (.*);

// ===== tb/atom_contact_energy_accumulator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atom_contact_energy_accumulator_tb: self-checking bench for the accumulator
// Sends contacts over the request channel and predicts each term and running
// score from its own copy of the probe width and the energy sum. Directed
// contacts cover the distance zones, the out-of-range cutoff and the probe
// width extremes; random contact lists follow under several probe widths,
// with idle bursts on both channels, then a final stream without idling.
// ----------------------------------------------------------------------------
module atom_contact_energy_accumulator_tb;

   localparam int     CW   = acea_pkg::COORD_WIDTH;
   localparam longint CMIN = -(longint'(1) << (CW - 1));
   localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint FAR  = longint'(1) << acea_pkg::FAR_BITS;

   typedef struct {
      logic signed [CW-1:0]                      first_x;
      logic signed [CW-1:0]                      first_y;
      logic signed [CW-1:0]                      first_z;
      logic signed [CW-1:0]                      second_x;
      logic signed [CW-1:0]                      second_y;
      logic signed [CW-1:0]                      second_z;
      logic [acea_pkg::DIST_WIDTH-1:0]           full_distance;
      logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  weight;
      logic                                      final_contact;
   } contact_type;

   typedef struct {
      logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  term;
      logic signed [acea_pkg::SUM_WIDTH-1:0]     score;
      logic                                      done_res;
   } outcome_type;

   logic                                      clock = 1'b0;
   logic                                      reset;
   logic                                      req_valid;
   logic                                      req_ready;
   logic signed [CW-1:0]                      req_first_x;
   logic signed [CW-1:0]                      req_first_y;
   logic signed [CW-1:0]                      req_first_z;
   logic signed [CW-1:0]                      req_second_x;
   logic signed [CW-1:0]                      req_second_y;
   logic signed [CW-1:0]                      req_second_z;
   logic [acea_pkg::DIST_WIDTH-1:0]           req_full_distance;
   logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  req_weight;
   logic                                      req_final_contact;
   logic                                      rsp_valid;
   logic                                      rsp_ready;
   logic signed [acea_pkg::WEIGHT_WIDTH-1:0]  rsp_term;
   logic signed [acea_pkg::SUM_WIDTH-1:0]     rsp_score;
   logic                                      rsp_done_res;
   logic                                      csr_valid;
   logic                                      csr_ready;
   logic [acea_pkg::PW_WIDTH-1:0]             csr_probe_width;

   // Predictor state, mirrored from the block.
   logic [acea_pkg::PW_WIDTH-1:0]             probe_width_model;
   longint                                    energy_total;
   outcome_type                               pending_outcomes[$];

   int mismatch_count;
   int results_checked;
   int contacts_sent;
   int lists_closed;
   int width_writes;
   int idle_odds;

   atom_contact_energy_accumulator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_x       (req_first_x),
      .req_first_y       (req_first_y),
      .req_first_z       (req_first_z),
      .req_second_x      (req_second_x),
      .req_second_y      (req_second_y),
      .req_second_z      (req_second_z),
      .req_full_distance (req_full_distance),
      .req_weight        (req_weight),
      .req_final_contact (req_final_contact),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_term          (rsp_term),
      .rsp_score         (rsp_score),
      .rsp_done_res      (rsp_done_res),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_probe_width   (csr_probe_width)
   );

   always #6 clock = ~clock;

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      int              b;
      root = 0;
      for (b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   function automatic longint clamp_sum(input longint v);
      if (v > longint'(acea_pkg::SUM_MAX)) return longint'(acea_pkg::SUM_MAX);
      if (v < longint'(acea_pkg::SUM_MIN)) return longint'(acea_pkg::SUM_MIN);
      return v;
   endfunction

   // Term and negated running score for one contact; advances the sum.
   function automatic outcome_type score_contact(input contact_type c);
      longint      dx, dy, dz, gap, limit, prod, mag, term, score;
      outcome_type o;
      dx = longint'(c.first_x) - longint'(c.second_x);
      dy = longint'(c.first_y) - longint'(c.second_y);
      dz = longint'(c.first_z) - longint'(c.second_z);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      term = 0;
      if (dx < FAR && dy < FAR && dz < FAR) begin
         gap   = longint'(int_sqrt(dx * dx + dy * dy + dz * dz));
         limit = longint'(c.full_distance) + longint'(probe_width_model);
         if (gap < longint'(c.full_distance)) begin
            term = longint'(c.weight);
         end else if (gap < limit) begin
            // Scaled weight, truncated toward zero.
            prod = longint'(c.weight) * (limit - gap);
            mag  = (prod < 0 ? -prod : prod) / longint'(probe_width_model);
            term = (prod < 0) ? -mag : mag;
         end
      end
      energy_total = clamp_sum(energy_total + term);
      score        = clamp_sum(-energy_total);
      o.term       = term[acea_pkg::WEIGHT_WIDTH-1:0];
      o.score      = score[acea_pkg::SUM_WIDTH-1:0];
      o.done_res   = c.final_contact;
      if (c.final_contact) energy_total = 0;
      return o;
   endfunction

   // Puts two coordinates at a random place so that a - b equals diff.
   function automatic void place_axis(input longint diff,
                                      output logic signed [CW-1:0] a,
                                      output logic signed [CW-1:0] b);
      longint lo, hi, v;
      lo = CMIN + (diff > 0 ? diff : 0);
      hi = CMAX + (diff < 0 ? diff : 0);
      v  = lo + longint'($urandom_range(0, 32'(hi - lo)));
      a  = CW'(v);
      b  = CW'(v - diff);
   endfunction

   function automatic contact_type place_contact(input longint dx, input longint dy,
                                                 input longint dz, input longint full,
                                                 input longint w, input bit last);
      contact_type c;
      place_axis(dx, c.first_x, c.second_x);
      place_axis(dy, c.first_y, c.second_y);
      place_axis(dz, c.first_z, c.second_z);
      c.full_distance = full[acea_pkg::DIST_WIDTH-1:0];
      c.weight        = w[acea_pkg::WEIGHT_WIDTH-1:0];
      c.final_contact = last;
      return c;
   endfunction

   // Mostly contacts near the fall-off zone; some out-of-range and raw noise.
   function automatic contact_type random_contact(input bit last);
      contact_type c;
      longint      diff [3];
      longint      gap, full, w;
      int          i, k, axis, kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         c.first_x       = CW'($urandom);
         c.first_y       = CW'($urandom);
         c.first_z       = CW'($urandom);
         c.second_x      = CW'($urandom);
         c.second_y      = CW'($urandom);
         c.second_z      = CW'($urandom);
         c.full_distance = acea_pkg::DIST_WIDTH'($urandom);
         c.weight        = acea_pkg::WEIGHT_WIDTH'($urandom);
         c.final_contact = last;
         return c;
      end
      for (i = 0; i < 3; i++) begin
         k       = $urandom_range(0, 16);
         diff[i] = longint'($urandom_range(0, (1 << k) - 1));
         if ($urandom_range(0, 1)) diff[i] = -diff[i];
      end
      if (kind == 1) begin
         // Right at the out-of-range cutoff on one axis.
         axis       = $urandom_range(0, 2);
         diff[axis] = FAR - longint'($urandom_range(0, 1));
         if ($urandom_range(0, 1)) diff[axis] = -diff[axis];
      end
      gap = longint'(int_sqrt(diff[0] * diff[0] + diff[1] * diff[1] + diff[2] * diff[2]));
      case ($urandom_range(0, 4))
         0: full = gap + 1 + longint'($urandom_range(0, 300));
         1: full = gap;
         2: full = gap - longint'($urandom_range(0, probe_width_model));
         3: full = gap - longint'(probe_width_model) - longint'($urandom_range(0, 300));
         default: full = longint'($urandom_range(0, 65535));
      endcase
      if (full < 0) full = 0;
      if (full > 65535) full = 65535;
      case ($urandom_range(0, 9))
         0: w = -32768;
         1: w = 32767;
         2: w = longint'($urandom_range(0, 2)) - 1;
         default: w = longint'($urandom_range(0, 65535)) - 32768;
      endcase
      return place_contact(diff[0], diff[1], diff[2], full, w, last);
   endfunction

   task automatic report_mismatch(input string text);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, text);
   endtask

   task automatic send_contact(input contact_type c);
      req_valid         <= 1'b1;
      req_first_x       <= c.first_x;
      req_first_y       <= c.first_y;
      req_first_z       <= c.first_z;
      req_second_x      <= c.second_x;
      req_second_y      <= c.second_y;
      req_second_z      <= c.second_z;
      req_full_distance <= c.full_distance;
      req_weight        <= c.weight;
      req_final_contact <= c.final_contact;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_outcomes.push_back(score_contact(c));
      contacts_sent++;
      if (c.final_contact) lists_closed++;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic send_list(input int length);
      int n;
      for (n = 0; n < length; n++) send_contact(random_contact(n == length - 1));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The block must be idle: every pending result is drained first.
   task automatic write_probe_width(input logic [acea_pkg::PW_WIDTH-1:0] value);
      drain_results();
      csr_valid       <= 1'b1;
      csr_probe_width <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid         <= 1'b0;
      probe_width_model  = value;
      width_writes++;
   endtask

   // Exact distances come from a single axis or a 3-4-5 triangle.
   task automatic test_reset_width();
      idle_odds = 4;
      send_contact(place_contact(0, 0, 0, 0, 32767, 0));
      send_contact(place_contact(0, 0, 0, 65535, -32768, 0));
      send_contact(place_contact(1000, 0, 0, 1000, 1000, 0));
      send_contact(place_contact(-1000, 0, 0, 999, -255, 0));
      send_contact(place_contact(0, 1256, 0, 1000, 12345, 0));
      send_contact(place_contact(0, 0, -1255, 1000, 32767, 0));
      send_contact(place_contact(900, -1200, 0, 1501, -1, 1));
      send_contact(place_contact(FAR, 0, 0, 65535, 32767, 0));
      send_contact(place_contact(FAR - 1, 0, 0, 65535, 32767, 0));
      send_contact(place_contact(0, -FAR, 0, 65535, -32768, 0));
      send_contact(place_contact(0, 0, FAR, 65535, 32767, 0));
      send_contact(place_contact(CMAX - CMIN, CMIN - CMAX, CMAX - CMIN, 0, 32767, 1));
      send_contact(place_contact(0, 0, 0, 100, 0, 1));
   endtask

   task automatic test_width_extremes();
      write_probe_width(1);
      send_contact(place_contact(500, 0, 0, 500, -32768, 0));
      send_contact(place_contact(0, 501, 0, 500, 32767, 0));
      send_contact(place_contact(0, 0, 499, 500, 777, 1));
      write_probe_width(16'hFFFF);
      send_contact(place_contact(0, 0, 0, 0, -32768, 0));
      send_contact(place_contact(65534, 0, 0, 0, -32768, 0));
      send_contact(place_contact(0, -32768, 0, 0, 32767, 0));
      send_contact(place_contact(0, 0, 32768, 0, -32767, 0));
      send_contact(place_contact(131070, 0, 0, 65535, 32767, 1));
      // An empty fall-off zone: full weight below full distance, else nothing.
      write_probe_width(0);
      send_contact(place_contact(700, 0, 0, 701, -32768, 0));
      send_contact(place_contact(0, 700, 0, 700, 32767, 0));
      send_contact(place_contact(0, 0, 0, 0, 32767, 1));
   endtask

   task automatic test_random_lists();
      logic [acea_pkg::PW_WIDTH-1:0] widths [6];
      int                            p, sent, len;
      widths = '{16'd256, 16'd1, 16'hFFFF, 16'($urandom_range(2, 65534)),
                 16'($urandom_range(1, 32)), 16'd0};
      for (p = 0; p < 6; p++) begin
         write_probe_width(widths[p]);
         sent = 0;
         while (sent < 270) begin
            len = $urandom_range(1, 12);
            if ($urandom_range(0, 15) == 0) len = $urandom_range(20, 60);
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : 4;
            send_list(len);
            sent += len;
         end
      end
   endtask

   task automatic test_steady_stream();
      int sent, len;
      idle_odds = 0;
      write_probe_width(16'($urandom_range(2, 600)));
      sent = 0;
      while (sent < 180) begin
         len = $urandom_range(1, 12);
         send_list(len);
         sent += len;
      end
   endtask

   initial begin : result_stall
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("result with no request outstanding: term %0d score %0d",
                                      rsp_term, rsp_score));
         end else begin
            want = pending_outcomes.pop_front();
            results_checked++;
            if (rsp_term !== want.term)
               report_mismatch($sformatf("result %0d term %0d, predicted %0d",
                                         results_checked, rsp_term, want.term));
            if (rsp_score !== want.score)
               report_mismatch($sformatf("result %0d score %0d, predicted %0d",
                                         results_checked, rsp_score, want.score));
            if (rsp_done_res !== want.done_res)
               report_mismatch($sformatf("result %0d done_res %b, predicted %b",
                                         results_checked, rsp_done_res, want.done_res));
         end
      end
   end

   initial begin : watchdog
      #12000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin : run_tests
      mismatch_count    = 0;
      results_checked   = 0;
      contacts_sent     = 0;
      lists_closed      = 0;
      width_writes      = 0;
      idle_odds         = 0;
      probe_width_model = acea_pkg::PW_RESET;
      energy_total      = 0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_first_x       <= '0;
      req_first_y       <= '0;
      req_first_z       <= '0;
      req_second_x      <= '0;
      req_second_y      <= '0;
      req_second_z      <= '0;
      req_full_distance <= '0;
      req_weight        <= '0;
      req_final_contact <= 1'b0;
      csr_valid         <= 1'b0;
      csr_probe_width   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_width();
      test_width_extremes();
      test_random_lists();
      test_steady_stream();

      drain_results();
      repeat (64) @(posedge clock);
      $display("Checked %0d results for %0d contacts in %0d lists.",
               results_checked, contacts_sent, lists_closed);
      $display("Probe width was rewritten %0d times, zero and full scale included.",
               width_writes);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/acea_pkg.sv
design/acea_isqrt.sv
design/acea_divu.sv
design/atom_contact_energy_accumulator.sv
design/acea_checker.sv
tb/atom_contact_energy_accumulator_tb.sv
